// File: rtl/pva_pkg.sv
// Package: shared types and constants for the polyphonic voice allocator.
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

    localparam int VOICES_DEF  = 4;
    localparam int SHOWN_SLOTS = 4;
    localparam logic [7:0] FREE_MARK = 8'hFF;

    typedef enum logic [1:0] {
        MODE_NOTE_ON      = 2'd0,
        MODE_NOTE_OFF     = 2'd1,
        MODE_LEARN_START  = 2'd2,
        MODE_LEARN_CANCEL = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [3:0] midi_channel;
        logic [6:0] note_number;
        logic [6:0] note_velocity;
    } t_in_item;

    typedef struct packed {
        logic       learning;
        logic [3:0] gate_mask;
        logic [7:0] voice0_note;
        logic [7:0] voice1_note;
        logic [7:0] voice2_note;
        logic [7:0] voice3_note;
        logic [7:0] voice0_velocity;
        logic [7:0] voice1_velocity;
        logic [7:0] voice2_velocity;
        logic [7:0] voice3_velocity;
        logic [6:0] base_note_out;
        logic [7:0] listen_channel_out;
    } t_out_item;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_pva_state;

    typedef struct packed {
        logic capture;
        logic apply;
    } t_pva_cmd;

endpackage

`default_nettype wire

// File: rtl/pva_if.sv
// Interfaces: valid/ready channels for event beats in and voice table beats out.
`timescale 1ns / 1ps
`default_nettype none

interface pva_in_if import pva_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pva_out_if import pva_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/pva_ctrl.sv
// Controller: sequences capture and update of one event and owns the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module pva_ctrl import pva_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_out_ready,
    output logic          o_out_valid,
    output t_pva_cmd      o_cmd,
    output t_pva_state    o_state
);

    t_pva_state r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                // take no beat while reset is held
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
                if (o_cmd.capture) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // update only once the result register is free or draining
                o_cmd.apply = !r_out_valid || i_out_ready;
                if (o_cmd.apply) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule

`default_nettype wire

// File: rtl/pva_datapath.sv
// Datapath: voice slot table, learn state, event latch and result register.
`timescale 1ns / 1ps
`default_nettype none

module pva_datapath import pva_pkg::*; #(
    parameter int VOICES = VOICES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_pva_cmd i_cmd,
    input  wire t_in_item i_item,
    output t_out_item     o_item
);

    t_in_item   r_item;
    logic [7:0] r_slot_note [VOICES];
    logic [7:0] r_slot_vel  [VOICES];
    logic [7:0] r_listen;
    logic [6:0] r_base;
    logic       r_learn;
    t_out_item  r_out;

    logic [7:0] n_slot_note [VOICES];
    logic [7:0] n_slot_vel  [VOICES];
    logic [7:0] n_listen;
    logic [6:0] n_base;
    logic       n_learn;
    t_out_item  n_out;

    logic       chan_hit;
    logic       found;
    logic [7:0] show_note [SHOWN_SLOTS];
    logic [7:0] show_vel  [SHOWN_SLOTS];

    // hold the accepted event beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        n_slot_note = r_slot_note;
        n_slot_vel  = r_slot_vel;
        n_listen    = r_listen;
        n_base      = r_base;
        n_learn     = r_learn;
        found       = 1'b0;
        chan_hit    = (r_listen == {4'b0000, r_item.midi_channel});
        case (r_item.mode)
            MODE_NOTE_ON: begin
                if (r_learn) begin
                    n_listen = {4'b0000, r_item.midi_channel};
                    n_base   = r_item.note_number;
                    n_learn  = 1'b0;
                    for (int i = 0; i < VOICES; i++) begin
                        n_slot_note[i] = FREE_MARK;
                    end
                end else if (chan_hit) begin
                    // lowest free slot wins; drop the note when all are busy
                    for (int i = 0; i < VOICES; i++) begin
                        if (!found && r_slot_note[i] == FREE_MARK) begin
                            n_slot_note[i] = {1'b0, r_item.note_number};
                            n_slot_vel[i]  = {1'b0, r_item.note_velocity};
                            found          = 1'b1;
                        end
                    end
                end
            end
            MODE_NOTE_OFF: begin
                if (!r_learn && chan_hit) begin
                    for (int i = 0; i < VOICES; i++) begin
                        if (r_slot_note[i] == {1'b0, r_item.note_number}) begin
                            n_slot_note[i] = FREE_MARK;
                            n_slot_vel[i]  = FREE_MARK;
                        end
                    end
                end
            end
            MODE_LEARN_START: begin
                n_learn = 1'b1;
            end
            MODE_LEARN_CANCEL: begin
                n_learn = 1'b0;
            end
            default: begin
                n_learn = r_learn;
            end
        endcase
    end

    // slots beyond the configured count show as free
    for (genvar g = 0; g < SHOWN_SLOTS; g++) begin : g_show
        if (g < VOICES) begin : g_real
            assign show_note[g] = n_slot_note[g];
            assign show_vel[g]  = n_slot_vel[g];
        end else begin : g_free
            assign show_note[g] = FREE_MARK;
            assign show_vel[g]  = FREE_MARK;
        end
    end

    always_comb begin
        n_out                    = '0;
        n_out.learning           = n_learn;
        n_out.gate_mask          = {show_note[3] != FREE_MARK, show_note[2] != FREE_MARK,
                                    show_note[1] != FREE_MARK, show_note[0] != FREE_MARK};
        n_out.voice0_note        = show_note[0];
        n_out.voice1_note        = show_note[1];
        n_out.voice2_note        = show_note[2];
        n_out.voice3_note        = show_note[3];
        n_out.voice0_velocity    = show_vel[0];
        n_out.voice1_velocity    = show_vel[1];
        n_out.voice2_velocity    = show_vel[2];
        n_out.voice3_velocity    = show_vel[3];
        n_out.base_note_out      = n_base;
        n_out.listen_channel_out = n_listen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                r_slot_note[i] <= FREE_MARK;
                r_slot_vel[i]  <= FREE_MARK;
            end
            r_listen <= FREE_MARK;
            r_base   <= '0;
            r_learn  <= 1'b0;
        end else if (i_cmd.apply) begin
            r_slot_note <= n_slot_note;
            r_slot_vel  <= n_slot_vel;
            r_listen    <= n_listen;
            r_base      <= n_base;
            r_learn     <= n_learn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

// File: rtl/poly_voice_allocator_unit.sv
// Top level: polyphonic voice allocator with channel learn, controller plus datapath.
//
// Usage:
//   i_in carries one MIDI event per beat (note on, note off, learn start,
//   learn cancel). o_out returns one beat per event with the whole voice
//   table (four shown slots), the gate mask, the learn flag, the learned base
//   note and the listened channel, all taken after the event has been applied.
// Timing:
//   An event is captured in the idle state and applied in the update state,
//   where the result register is loaded; the result beat is valid from the
//   cycle after that. An event takes one step to capture and one for the slot
//   compare and first-free pick that update the table; the update waits while
//   a held result is neither free nor being drained.
// Reset:
//   All slots free (note and velocity 255), no channel learned (255), base
//   note 0, not learning, no result pending.
// Stalls:
//   The result register holds its beat until taken. The next event may be
//   captured meanwhile, but its update waits until the register is free or
//   is being drained in the same cycle, so no result is lost or overwritten.
`timescale 1ns / 1ps
`default_nettype none

module poly_voice_allocator_unit import pva_pkg::*; #(
    parameter int VOICES = VOICES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pva_in_if.sink     i_in,
    pva_out_if.source  o_out
);

    t_pva_cmd   cmd;
    t_pva_state state;

    // controller: handshakes and sequencing
    pva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .o_state     (state)
    );

    // datapath: slot table, learn state and result register
    pva_datapath #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in.data),
        .o_item  (o_out.data)
    );

    // a captured event is always followed by an update state
    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> state == ST_EXEC)
        else $error("capture not followed by update state");

    // gate mask agrees with the shown slot notes
    a_gate_matches_notes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            (o_out.data.gate_mask[0] == (o_out.data.voice0_note != FREE_MARK)) &&
            (o_out.data.gate_mask[1] == (o_out.data.voice1_note != FREE_MARK)) &&
            (o_out.data.gate_mask[2] == (o_out.data.voice2_note != FREE_MARK)) &&
            (o_out.data.gate_mask[3] == (o_out.data.voice3_note != FREE_MARK)))
        else $error("gate mask disagrees with slot notes");

    // listened channel is either unlearned or a four-bit channel
    a_listen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.listen_channel_out == FREE_MARK ||
                         o_out.data.listen_channel_out[7:4] == 4'h0))
        else $error("listened channel out of range");

    // no update while a held result is neither free nor drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !cmd.apply)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/tb_poly_voice_allocator_unit.sv
// Testbench: MIDI event beats into the voice allocator, every voice table beat checked.
`timescale 1ns / 1ps

module tb_poly_voice_allocator_unit;
    import pva_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_EVENTS = 1600;
    // Run-length bound for the watchdog; it also covers the long hold.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_CAP     = 100;
    localparam int HOLD_AT_BEAT  = 400;
    localparam int HOLD_CYCLES   = 300;

    // Receiver stall patterns, switched at random.
    typedef enum logic [1:0] {
        RX_STEADY = 2'd0,
        RX_COIN   = 2'd1,
        RX_THIRDS = 2'd2,
        RX_MOSTLY = 2'd3
    } t_rx_style;

    logic i_clk;
    logic i_rst_n;

    pva_in_if  ev_if ();
    pva_out_if tbl_if ();

    poly_voice_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_if),
        .o_out   (tbl_if)
    );

    // Event beats waiting to be offered, and the voice tables they should produce.
    t_in_item  pending_events[$];
    t_out_item expected_tables[$];

    // Predicted allocator state.
    logic [7:0] voice_note [VOICES_DEF];
    logic [7:0] voice_vel  [VOICES_DEF];
    logic [7:0] heard_chan;
    logic [6:0] learned_base;
    logic       learn_armed;

    int fail_count      = 0;
    int cycle_count     = 0;
    int events_accepted = 0;

    // Stimulus shadow of the channel the block should be listening to (-1: none yet).
    int         gen_chan     = -1;
    bit         gen_learning = 1'b0;
    logic [6:0] note_pool [6];

    // Sender burst/gap bookkeeping.
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver pattern bookkeeping.
    t_rx_style rx_style   = RX_STEADY;
    int        style_left = 0;
    int        rx_phase   = 0;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;

    // Apply one event to the predicted state and return the table it leaves behind.
    function automatic t_out_item apply_event(t_in_item ev);
        t_out_item  tbl;
        logic [7:0] shown_note;
        logic [7:0] shown_vel;
        bit         placed;
        placed = 1'b0;
        case (ev.mode)
            MODE_NOTE_ON: begin
                if (learn_armed) begin
                    // Learn: take channel and base note, free every note, keep velocities.
                    heard_chan   = {4'd0, ev.midi_channel};
                    learned_base = ev.note_number;
                    for (int i = 0; i < VOICES_DEF; i++) voice_note[i] = FREE_MARK;
                    learn_armed = 1'b0;
                end else if (heard_chan == {4'd0, ev.midi_channel}) begin
                    // First free slot wins; drop the note when all are busy.
                    for (int i = 0; i < VOICES_DEF; i++) begin
                        if (!placed && voice_note[i] == FREE_MARK) begin
                            voice_note[i] = {1'b0, ev.note_number};
                            voice_vel[i]  = {1'b0, ev.note_velocity};
                            placed = 1'b1;
                        end
                    end
                end
            end
            MODE_NOTE_OFF: begin
                // Free every slot holding the note; ignored while learning.
                if (!learn_armed && heard_chan == {4'd0, ev.midi_channel}) begin
                    for (int i = 0; i < VOICES_DEF; i++) begin
                        if (voice_note[i] == {1'b0, ev.note_number}) begin
                            voice_note[i] = FREE_MARK;
                            voice_vel[i]  = FREE_MARK;
                        end
                    end
                end
            end
            MODE_LEARN_START:  learn_armed = 1'b1;
            MODE_LEARN_CANCEL: learn_armed = 1'b0;
            default: ;
        endcase

        tbl = '0;
        tbl.learning = learn_armed;
        for (int i = 0; i < SHOWN_SLOTS; i++) begin
            shown_note = FREE_MARK;
            shown_vel  = FREE_MARK;
            if (i < VOICES_DEF) begin
                shown_note = voice_note[i];
                shown_vel  = voice_vel[i];
            end
            tbl.gate_mask[i] = (shown_note != FREE_MARK);
            case (i)
                0: begin
                    tbl.voice0_note = shown_note;
                    tbl.voice0_velocity = shown_vel;
                end
                1: begin
                    tbl.voice1_note = shown_note;
                    tbl.voice1_velocity = shown_vel;
                end
                2: begin
                    tbl.voice2_note = shown_note;
                    tbl.voice2_velocity = shown_vel;
                end
                default: begin
                    tbl.voice3_note = shown_note;
                    tbl.voice3_velocity = shown_vel;
                end
            endcase
        end
        tbl.base_note_out      = learned_base;
        tbl.listen_channel_out = heard_chan;
        return tbl;
    endfunction

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", field, got, want));
    endtask

    // Queue one event beat and track which channel the stimulus expects to be heard.
    task automatic queue_event(t_mode mode, logic [3:0] chan, logic [6:0] note,
                               logic [6:0] vel);
        t_in_item ev;
        ev.mode          = mode;
        ev.midi_channel  = chan;
        ev.note_number   = note;
        ev.note_velocity = vel;
        pending_events.push_back(ev);
        case (mode)
            MODE_NOTE_ON: begin
                if (gen_learning) begin
                    gen_chan     = chan;
                    gen_learning = 1'b0;
                end
            end
            MODE_LEARN_START:  gen_learning = 1'b1;
            MODE_LEARN_CANCEL: gen_learning = 1'b0;
            default: ;
        endcase
    endtask

    // Clock: 8 ns period.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Reset: held low once at start-up, with every input at a known value.
    initial begin
        i_rst_n       = 1'b0;
        ev_if.valid   = 1'b0;
        ev_if.data    = '0;
        tbl_if.ready  = 1'b0;
        for (int i = 0; i < VOICES_DEF; i++) begin
            voice_note[i] = FREE_MARK;
            voice_vel[i]  = FREE_MARK;
        end
        heard_chan   = FREE_MARK;
        learned_base = 7'd0;
        learn_armed  = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sender: offer queued beats in bursts of random length with random gaps.
    // An offered beat is held until taken; the expected table is worked out
    // at the edge where the beat is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ev_if.valid <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else begin
            if (ev_if.valid && ev_if.ready) begin
                expected_tables.push_back(apply_event(ev_if.data));
                events_accepted++;
            end
            // Otherwise hold the offered beat until the block takes it.
            if (!ev_if.valid || ev_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    ev_if.valid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    ev_if.valid <= 1'b1;
                    ev_if.data  <= pending_events.pop_front();
                    burst_left--;
                    if (burst_left == 0) begin
                        // A third of the bursts run straight into the next one.
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    ev_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a pattern of its own, with one long hold-off partway
    // through so that the result register fills and the event input backs up.
    always @(posedge i_clk) begin
        if (!hold_done && events_accepted >= HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            tbl_if.ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style   = t_rx_style'($urandom_range(0, 3));
                style_left = $urandom_range(32, 200);
            end
            style_left--;
            rx_phase++;
            case (rx_style)
                RX_STEADY: tbl_if.ready <= 1'b1;
                RX_COIN:   tbl_if.ready <= 1'($urandom_range(0, 1));
                RX_THIRDS: tbl_if.ready <= (rx_phase % 3 == 0);
                default:   tbl_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: compare each accepted table beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && tbl_if.valid && tbl_if.ready) begin
            got = tbl_if.data;
            if (expected_tables.size() == 0) begin
                report_mismatch("table beat arrived with nothing expected");
            end else begin
                want = expected_tables.pop_front();
                check_field("learning", 8'(got.learning), 8'(want.learning));
                check_field("gate_mask", 8'(got.gate_mask), 8'(want.gate_mask));
                check_field("voice0_note", got.voice0_note, want.voice0_note);
                check_field("voice1_note", got.voice1_note, want.voice1_note);
                check_field("voice2_note", got.voice2_note, want.voice2_note);
                check_field("voice3_note", got.voice3_note, want.voice3_note);
                check_field("voice0_velocity", got.voice0_velocity, want.voice0_velocity);
                check_field("voice1_velocity", got.voice1_velocity, want.voice1_velocity);
                check_field("voice2_velocity", got.voice2_velocity, want.voice2_velocity);
                check_field("voice3_velocity", got.voice3_velocity, want.voice3_velocity);
                check_field("base_note_out", 8'(got.base_note_out), 8'(want.base_note_out));
                check_field("listen_channel_out", got.listen_channel_out,
                            want.listen_channel_out);
            end
        end
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus: directed events first, then random ones; then drain and judge.
    initial begin
        int         r;
        int         n;
        logic [3:0] ch;
        logic [6:0] nt;

        foreach (note_pool[k]) note_pool[k] = 7'($urandom_range(0, 127));

        // Nothing learned yet: note on and note off are both ignored.
        queue_event(MODE_NOTE_ON,  4'd0,  7'd60,  7'd100);
        queue_event(MODE_NOTE_OFF, 4'd0,  7'd60,  7'd0);
        // Cancel while not learning, then start twice (second is a no-op).
        queue_event(MODE_LEARN_CANCEL, 4'd3, 7'd1, 7'd2);
        queue_event(MODE_LEARN_START,  4'd5, 7'd9, 7'd9);
        queue_event(MODE_LEARN_START,  4'd6, 7'd8, 7'd7);
        // Note off while learning is ignored.
        queue_event(MODE_NOTE_OFF, 4'd15, 7'd127, 7'd127);
        // Learn the top channel and top note.
        queue_event(MODE_NOTE_ON, 4'd15, 7'd127, 7'd127);
        // Fill all four slots, with a duplicate note and one foreign-channel note between.
        queue_event(MODE_NOTE_ON, 4'd15, 7'd0,   7'd0);
        queue_event(MODE_NOTE_ON, 4'd15, 7'd127, 7'd127);
        queue_event(MODE_NOTE_ON, 4'd14, 7'd50,  7'd50);
        queue_event(MODE_NOTE_ON, 4'd15, 7'd0,   7'd5);
        queue_event(MODE_NOTE_ON, 4'd15, 7'd64,  7'd1);
        // Table full: drop this one.
        queue_event(MODE_NOTE_ON, 4'd15, 7'd10,  7'd90);
        // Release the duplicate note from both slots; foreign note off is ignored.
        queue_event(MODE_NOTE_OFF, 4'd15, 7'd0,   7'd33);
        queue_event(MODE_NOTE_OFF, 4'd14, 7'd127, 7'd0);
        // Lowest free slot gets the next note.
        queue_event(MODE_NOTE_ON, 4'd15, 7'd33,  7'd77);
        // Start, cancel, start again, then learn channel 0 and base note 0;
        // notes are freed but velocities stay.
        queue_event(MODE_LEARN_START,  4'd0, 7'd0, 7'd0);
        queue_event(MODE_LEARN_CANCEL, 4'd0, 7'd0, 7'd0);
        queue_event(MODE_LEARN_START,  4'd9, 7'd90, 7'd90);
        queue_event(MODE_NOTE_ON, 4'd0, 7'd0, 7'd127);
        // Note off for a note nobody holds, then a fresh note with zero velocity.
        queue_event(MODE_NOTE_OFF, 4'd0, 7'd99,  7'd12);
        queue_event(MODE_NOTE_ON,  4'd0, 7'd127, 7'd0);
        queue_event(MODE_NOTE_OFF, 4'd0, 7'd127, 7'd127);

        // Random part: mostly note traffic on the heard channel drawn from a small
        // note pool so that releases hit, with learn sequences and some noise.
        n = 0;
        while (n < RANDOM_EVENTS) begin
            r  = $urandom_range(0, 99);
            ch = (gen_chan < 0 || $urandom_range(0, 9) == 0) ?
                 4'($urandom_range(0, 15)) : 4'(gen_chan);
            nt = ($urandom_range(0, 4) == 0) ?
                 7'($urandom_range(0, 127)) : note_pool[$urandom_range(0, 5)];
            if (r < 45) begin
                queue_event(MODE_NOTE_ON, ch, nt, 7'($urandom_range(0, 127)));
                n++;
            end else if (r < 85) begin
                queue_event(MODE_NOTE_OFF, ch, nt, 7'($urandom_range(0, 127)));
                n++;
            end else if (r < 92) begin
                queue_event(MODE_LEARN_START, 4'($urandom_range(0, 15)),
                            7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                if ($urandom_range(0, 3) == 0) begin
                    queue_event(MODE_LEARN_CANCEL, 4'($urandom_range(0, 15)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                end else begin
                    foreach (note_pool[k]) note_pool[k] = 7'($urandom_range(0, 127));
                    queue_event(MODE_NOTE_ON, 4'($urandom_range(0, 15)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                end
                n += 2;
            end else if (r < 96) begin
                queue_event(MODE_LEARN_CANCEL, ch, nt, 7'($urandom_range(0, 127)));
                n++;
            end else begin
                queue_event(t_mode'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                            7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                n++;
            end
        end

        // Wait for every beat to go in and every table to come back.
        while (pending_events.size() > 0 || ev_if.valid || expected_tables.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_tables.size() != 0)
            report_mismatch($sformatf("%0d table beats never arrived",
                                      expected_tables.size()));

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
